// File: rtl/bea_pkg.sv
// Package for the button edge tracker: phase and command codes, register
// indexes, reset values, field widths, structs passed between modules and phase steps.
// No dependencies.
package bea_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned ButtonW   = 3;
  localparam int unsigned AxisW     = 16;
  localparam int unsigned MaskW     = 8;
  localparam int unsigned DeadzoneW = 15;
  localparam int unsigned DelayW    = 8;
  localparam int unsigned HoldW     = 9;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 15;
  localparam int unsigned NumDirs   = 4;

  localparam int unsigned DirUp    = 0;
  localparam int unsigned DirDown  = 1;
  localparam int unsigned DirLeft  = 2;
  localparam int unsigned DirRight = 3;

  localparam logic [CfgIdxW-1:0] CFG_DEADZONE      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_DELAY   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_PERIOD = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_ENABLE = 2'd3;

  localparam logic [DeadzoneW-1:0] DeadzoneRst     = 15'd8192;
  localparam logic [DelayW-1:0]    FirstDelayRst   = 8'd30;
  localparam logic [DelayW-1:0]    RepeatPeriodRst = 8'd12;

  localparam logic AxisVertical = 1'b0;

  typedef enum logic [1:0] {
    PH_OFF      = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_ON       = 2'd2,
    PH_RELEASED = 2'd3
  } phase_e;

  typedef enum logic [CmdW-1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_AXIS    = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [DeadzoneW-1:0] deadzone;
    logic [DelayW-1:0]    first_delay;
    logic [DelayW-1:0]    repeat_period;
    logic                 repeat_enable;
  } cfg_t;

  typedef struct packed {
    cmd_e                    cmd;
    logic [ButtonW-1:0]      button;
    logic                    axis_select;
    logic signed [AxisW-1:0] axis_value;
  } item_t;

  typedef struct packed {
    logic [MaskW-1:0] pressed_mask;
    logic [MaskW-1:0] held_mask;
    logic [MaskW-1:0] released_mask;
  } res_t;

  function automatic phase_e press_next(phase_e ph);
    phase_e nxt;
    nxt = ph;
    if (ph == PH_OFF || ph == PH_RELEASED) nxt = PH_PRESSED;
    return nxt;
  endfunction

  function automatic phase_e release_next(phase_e ph);
    phase_e nxt;
    nxt = ph;
    if (ph == PH_ON || ph == PH_PRESSED) nxt = PH_RELEASED;
    return nxt;
  endfunction

endpackage

// File: rtl/bea_in_if.sv
// Input channel of the button edge tracker: valid/ready handshake and one event.
// Depends on bea_pkg for the field widths.
interface bea_in_if import bea_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CmdW-1:0]         cmd;
  logic [ButtonW-1:0]      button;
  logic                    axis_select;
  logic signed [AxisW-1:0] axis_value;

  modport source (output valid, cmd, button, axis_select, axis_value, input ready);
  modport sink   (input valid, cmd, button, axis_select, axis_value, output ready);
endinterface

// File: rtl/bea_out_if.sv
// Result channel of the button edge tracker: valid/ready handshake and three masks.
// Depends on bea_pkg for the mask width.
interface bea_out_if import bea_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MaskW-1:0] pressed_mask;
  logic [MaskW-1:0] held_mask;
  logic [MaskW-1:0] released_mask;

  modport source (output valid, pressed_mask, held_mask, released_mask, input ready);
  modport sink   (input valid, pressed_mask, held_mask, released_mask, output ready);
endinterface

// File: rtl/bea_cfg_regs.sv
// Configuration registers of the button edge tracker, written through a plain
// write port. Depends on bea_pkg.
module bea_cfg_regs import bea_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [CfgIdxW-1:0]  idx_i,
  input  logic [CfgDataW-1:0] data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        CFG_DEADZONE:      cfg_d.deadzone      = data_i[DeadzoneW-1:0];
        CFG_FIRST_DELAY:   cfg_d.first_delay   = data_i[DelayW-1:0];
        CFG_REPEAT_PERIOD: cfg_d.repeat_period = data_i[DelayW-1:0];
        CFG_REPEAT_ENABLE: cfg_d.repeat_enable = data_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadzone      <= DeadzoneRst;
      cfg_q.first_delay   <= FirstDelayRst;
      cfg_q.repeat_period <= RepeatPeriodRst;
      cfg_q.repeat_enable <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/bea_core.sv
// Button phase state, hold counters and stick history, with the combinational
// update for one event and the tick masks. Depends on bea_pkg.
module bea_core import bea_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  go_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  localparam int unsigned MaskN = (NUM_BUTTONS < MaskW) ? NUM_BUTTONS : MaskW;
  localparam int unsigned TickW = HoldW + 1;
  localparam int unsigned CmpW  = AxisW + 1;

  phase_e                  phase_q [NUM_BUTTONS];
  phase_e                  phase_d [NUM_BUTTONS];
  phase_e                  phase_r [NUM_BUTTONS];
  logic [HoldW-1:0]        hold_q  [NumDirs];
  logic [HoldW-1:0]        hold_d  [NumDirs];
  logic signed [AxisW-1:0] last_x_q, last_x_d, last_y_q, last_y_d;

  logic signed [AxisW-1:0] old_v;
  logic signed [CmpW-1:0]  v_s, old_s, pdz, ndz;
  logic                    neg_press, neg_rel, pos_rel, pos_press;
  logic [TickW-1:0]        first_t, second_t, cnt;
  res_t                    res;

  // Stick thresholds and the ordered edge chain for the selected axis.
  always_comb begin
    old_v = (item_i.axis_select == AxisVertical) ? last_y_q : last_x_q;
    v_s   = $signed({item_i.axis_value[AxisW-1], item_i.axis_value});
    old_s = $signed({old_v[AxisW-1], old_v});
    pdz   = $signed({2'b00, cfg_i.deadzone});
    ndz   = -pdz;
    neg_press = 1'b0;
    neg_rel   = 1'b0;
    pos_rel   = 1'b0;
    pos_press = 1'b0;
    if (v_s <= ndz && old_s > ndz)       neg_press = 1'b1;
    else if (v_s > ndz && old_s <= ndz)  neg_rel   = 1'b1;
    else if (v_s < pdz && old_s >= pdz)  pos_rel   = 1'b1;
    else if (v_s >= pdz && old_s < pdz)  pos_press = 1'b1;
  end

  always_comb begin
    first_t  = {2'b00, cfg_i.first_delay};
    second_t = {2'b00, cfg_i.first_delay} + {2'b00, cfg_i.repeat_period};
    cnt      = '0;
    phase_d  = phase_q;
    phase_r  = phase_q;
    hold_d   = hold_q;
    last_x_d = last_x_q;
    last_y_d = last_y_q;
    res      = '0;
    if (go_i) begin
      unique case (item_i.cmd)
        CMD_PRESS: begin
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (int'(item_i.button) == i) phase_d[i] = press_next(phase_q[i]);
          end
        end
        CMD_RELEASE: begin
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (int'(item_i.button) == i) phase_d[i] = release_next(phase_q[i]);
          end
        end
        CMD_AXIS: begin
          if (item_i.axis_select == AxisVertical) begin
            if (neg_press) phase_d[DirUp]   = press_next(phase_q[DirUp]);
            if (neg_rel)   phase_d[DirUp]   = release_next(phase_q[DirUp]);
            if (pos_rel)   phase_d[DirDown] = release_next(phase_q[DirDown]);
            if (pos_press) phase_d[DirDown] = press_next(phase_q[DirDown]);
            last_y_d = item_i.axis_value;
          end else begin
            if (neg_press) phase_d[DirLeft]  = press_next(phase_q[DirLeft]);
            if (neg_rel)   phase_d[DirLeft]  = release_next(phase_q[DirLeft]);
            if (pos_rel)   phase_d[DirRight] = release_next(phase_q[DirRight]);
            if (pos_press) phase_d[DirRight] = press_next(phase_q[DirRight]);
            last_x_d = item_i.axis_value;
          end
        end
        CMD_TICK: begin
          // Auto-repeat runs on the phases before the edges are retired.
          if (cfg_i.repeat_enable) begin
            for (int d = 0; d < NumDirs; d++) begin
              if (phase_q[d] == PH_ON || phase_q[d] == PH_PRESSED) begin
                cnt = {1'b0, hold_q[d]} + TickW'(1);
                if (cnt == first_t || cnt == second_t) phase_r[d] = PH_PRESSED;
                if (cnt >= second_t) cnt = first_t;
                hold_d[d] = cnt[HoldW-1:0];
              end else begin
                hold_d[d] = '0;
              end
            end
          end
          for (int i = 0; i < MaskN; i++) begin
            res.pressed_mask[i]  = (phase_r[i] == PH_PRESSED);
            res.held_mask[i]     = (phase_r[i] == PH_PRESSED) || (phase_r[i] == PH_ON);
            res.released_mask[i] = (phase_r[i] == PH_RELEASED);
          end
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (phase_r[i] == PH_PRESSED)       phase_d[i] = PH_ON;
            else if (phase_r[i] == PH_RELEASED) phase_d[i] = PH_OFF;
            else                                phase_d[i] = phase_r[i];
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUTTONS; i++) phase_q[i] <= PH_OFF;
      for (int d = 0; d < NumDirs; d++) hold_q[d] <= '0;
      last_x_q <= '0;
      last_y_q <= '0;
    end else begin
      phase_q  <= phase_d;
      hold_q   <= hold_d;
      last_x_q <= last_x_d;
      last_y_q <= last_y_d;
    end
  end

  assign res_o = res;

endmodule

// File: rtl/button_edge_autorepeat.sv
// Top level of the button edge tracker: input register, core and result register.
// Depends on bea_pkg, bea_in_if, bea_out_if, bea_cfg_regs and bea_core.
//
// Events arrive on in_i: press, release, stick axis move or frame tick. Only a
// frame tick gives a result on out_o: the pressed, held and released masks,
// with direction auto-repeat applied first when it is enabled.
// An event is taken into an input register on its transfer and is applied to the
// state as it leaves that register; a tick's masks are loaded into the result
// register at the same time and are offered on out_o from there. One event is
// taken per cycle while no tick waits in the input register.
// The result register holds a finished result until it is taken; events that
// give no result keep flowing while it waits, and a tick waits in the input
// register only when the result register is full and not being emptied.
// Reset clears all buttons to off, the hold counts and stick history to zero,
// and the registers to deadzone 8192, first delay 30, period 12, repeat on.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_data_i; the user must
// write them only while the block is idle, which the block itself does not enforce.
module button_edge_autorepeat import bea_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bea_in_if.sink              in_i,
  bea_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t  cfg;
  item_t item_q, item_d;
  logic  in_valid_q, in_valid_d;
  res_t  core_res, res_q, res_d;
  logic  out_valid_q, out_valid_d;
  logic  accept, advance, out_free, is_tick;

  assign out_free = !out_valid_q || out_o.ready;
  assign is_tick  = (item_q.cmd == CMD_TICK);
  assign advance  = in_valid_q && (!is_tick || out_free);
  assign in_i.ready = !in_valid_q || advance;
  assign accept   = in_i.valid && in_i.ready;

  always_comb begin
    item_d = item_q;
    if (accept) begin
      item_d.cmd         = cmd_e'(in_i.cmd);
      item_d.button      = in_i.button;
      item_d.axis_select = in_i.axis_select;
      item_d.axis_value  = in_i.axis_value;
    end
    in_valid_d = accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (advance && is_tick) begin
      res_d       = core_res;
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  bea_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  bea_core #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (core_res)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.pressed_mask  = res_q.pressed_mask;
  assign out_o.held_mask     = res_q.held_mask;
  assign out_o.released_mask = res_q.released_mask;

endmodule

// File: verif/button_edge_autorepeat_tb.sv
// Self-checking testbench for button_edge_autorepeat: directed and random events,
// with its own prediction of the button phases, auto-repeat counts and tick masks.
// Depends on bea_pkg, bea_in_if, bea_out_if and the button_edge_autorepeat RTL.
module button_edge_autorepeat_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bea_pkg::*;

  localparam int NumBtn        = 8;
  localparam int StallLen      = 60;
  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 4;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  bea_in_if  in_ch ();
  bea_out_if out_ch ();

  button_edge_autorepeat #(.NUM_BUTTONS(NumBtn)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted state of the block and its register copies.
  phase_e               btn_phase [NumBtn];
  logic [HoldW-1:0]     hold_cnt [NumDirs];
  int                   stick_x;
  int                   stick_y;
  logic [DeadzoneW-1:0] dz_cfg;
  logic [DelayW-1:0]    fd_cfg;
  logic [DelayW-1:0]    rp_cfg;
  logic                 en_cfg;

  item_t       event_q [$];
  res_t        tick_masks_q [$];
  item_t       cur_ev;
  res_t        tick_res;
  res_t        want;
  bit          in_fire;
  bit          idle_on;
  bit          long_stall_req;
  int          in_gap;
  int          out_gap;
  int          stall_left;
  int          mismatches;
  int unsigned idle_cycles;

  function automatic void mark_press(int unsigned idx);
    if (idx < NumBtn && (btn_phase[idx] == PH_OFF || btn_phase[idx] == PH_RELEASED)) begin
      btn_phase[idx] = PH_PRESSED;
    end
  endfunction

  function automatic void mark_release(int unsigned idx);
    if (idx < NumBtn && (btn_phase[idx] == PH_ON || btn_phase[idx] == PH_PRESSED)) begin
      btn_phase[idx] = PH_RELEASED;
    end
  endfunction

  // Applies one event to the predicted state; returns 1 with the masks on a tick.
  function automatic bit apply_event(input item_t ev, output res_t masks);
    int          v;
    int          prior;
    int          dz;
    int          t;
    int          second;
    int unsigned neg;
    int unsigned pos;
    masks = '0;
    v     = int'($signed(ev.axis_value));
    dz    = int'(dz_cfg);
    case (ev.cmd)
      CMD_PRESS: begin
        mark_press(ev.button);
        return 1'b0;
      end
      CMD_RELEASE: begin
        mark_release(ev.button);
        return 1'b0;
      end
      CMD_AXIS: begin
        if (ev.axis_select == AxisVertical) begin
          prior   = stick_y;
          neg     = DirUp;
          pos     = DirDown;
          stick_y = v;
        end else begin
          prior   = stick_x;
          neg     = DirLeft;
          pos     = DirRight;
          stick_x = v;
        end
        // Only the first matching edge of the chain takes effect.
        if (v <= -dz && prior > -dz) mark_press(neg);
        else if (v > -dz && prior <= -dz) mark_release(neg);
        else if (v < dz && prior >= dz) mark_release(pos);
        else if (v >= dz && prior < dz) mark_press(pos);
        return 1'b0;
      end
      default: begin
        if (en_cfg) begin
          second = int'(fd_cfg) + int'(rp_cfg);
          for (int d = 0; d < NumDirs; d++) begin
            if (btn_phase[d] == PH_ON || btn_phase[d] == PH_PRESSED) begin
              t = int'(hold_cnt[d]) + 1;
              if (t == int'(fd_cfg) || t == second) btn_phase[d] = PH_PRESSED;
              if (t >= second) t = int'(fd_cfg);
              hold_cnt[d] = t[HoldW-1:0];
            end else begin
              hold_cnt[d] = '0;
            end
          end
        end
        for (int i = 0; i < NumBtn && i < MaskW; i++) begin
          masks.pressed_mask[i]  = (btn_phase[i] == PH_PRESSED);
          masks.held_mask[i]     = (btn_phase[i] == PH_PRESSED || btn_phase[i] == PH_ON);
          masks.released_mask[i] = (btn_phase[i] == PH_RELEASED);
        end
        for (int i = 0; i < NumBtn; i++) begin
          if (btn_phase[i] == PH_PRESSED) btn_phase[i] = PH_ON;
          else if (btn_phase[i] == PH_RELEASED) btn_phase[i] = PH_OFF;
        end
        return 1'b1;
      end
    endcase
  endfunction

  function automatic item_t make_ev(cmd_e c, int unsigned b, int unsigned a, int v);
    item_t ev;
    ev.cmd         = c;
    ev.button      = b[ButtonW-1:0];
    ev.axis_select = a[0];
    ev.axis_value  = v[AxisW-1:0];
    return ev;
  endfunction

  // Stick positions cluster on the deadzone edges and the rails.
  function automatic int pick_axis();
    int dz;
    dz = int'(dz_cfg);
    case ($urandom_range(0, 7))
      0: return int'($urandom);
      1: return dz;
      2: return dz - 1;
      3: return -dz;
      4: return -dz + 1;
      5: return 32767;
      6: return -32768;
      default: return 0;
    endcase
  endfunction

  function automatic item_t rand_event(int tick_pct);
    cmd_e c;
    if ($urandom_range(0, 99) < tick_pct) begin
      c = CMD_TICK;
    end else begin
      case ($urandom_range(0, 2))
        0: c = CMD_PRESS;
        1: c = CMD_RELEASE;
        default: c = CMD_AXIS;
      endcase
    end
    return make_ev(c, $urandom_range(0, 7), $urandom_range(0, 1), pick_axis());
  endfunction

  // Mixes single random events with a direction pressed and then held over ticks.
  task automatic queue_random(input int n, input int tick_pct);
    int made;
    int ticks;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) < 2) begin
        event_q.push_back(make_ev(CMD_PRESS, $urandom_range(0, 3), $urandom_range(0, 1),
                                  int'($urandom)));
        ticks = $urandom_range(1, 40);
        repeat (ticks) begin
          event_q.push_back(make_ev(CMD_TICK, $urandom_range(0, 7), $urandom_range(0, 1),
                                    int'($urandom)));
        end
        made += ticks + 1;
      end else begin
        event_q.push_back(rand_event(tick_pct));
        made++;
      end
    end
  endtask

  task automatic queue_directed();
    for (int i = 0; i < NumBtn; i++) event_q.push_back(make_ev(CMD_PRESS, i, 0, 0));
    event_q.push_back(make_ev(CMD_PRESS, 5, 0, 0));
    event_q.push_back(make_ev(CMD_TICK, 0, 0, 0));
    event_q.push_back(make_ev(CMD_RELEASE, DirUp, 0, 0));
    event_q.push_back(make_ev(CMD_RELEASE, DirDown, 0, 0));
    event_q.push_back(make_ev(CMD_RELEASE, DirLeft, 0, 0));
    event_q.push_back(make_ev(CMD_RELEASE, DirRight, 0, 0));
    event_q.push_back(make_ev(CMD_RELEASE, 7, 0, 0));
    event_q.push_back(make_ev(CMD_RELEASE, 7, 0, 0));
    event_q.push_back(make_ev(CMD_TICK, 0, 0, 0));
    // Stick walk: up press, up release, right press, right release, left press.
    event_q.push_back(make_ev(CMD_AXIS, 0, 0, -32768));
    event_q.push_back(make_ev(CMD_AXIS, 0, 0, 32767));
    event_q.push_back(make_ev(CMD_AXIS, 0, 1, 8192));
    event_q.push_back(make_ev(CMD_AXIS, 0, 1, 8191));
    event_q.push_back(make_ev(CMD_AXIS, 0, 1, -8192));
    event_q.push_back(make_ev(CMD_TICK, 0, 0, 0));
    event_q.push_back(make_ev(CMD_RELEASE, 6, 0, 0));
    event_q.push_back(make_ev(CMD_TICK, 0, 0, 0));
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_DEADZONE:      dz_cfg = val[DeadzoneW-1:0];
      CFG_FIRST_DELAY:   fd_cfg = val[DelayW-1:0];
      CFG_REPEAT_PERIOD: rp_cfg = val[DelayW-1:0];
      default:           en_cfg = val[0];
    endcase
  endtask

  // Waits until every queued event has been taken and every tick result has come.
  task automatic drain();
    do @(posedge clk_i);
    while (event_q.size() != 0 || in_ch.valid || tick_masks_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned dz, input int unsigned fd, input int unsigned rp,
                           input int unsigned en, input int n, input int tick_pct);
    drain();
    write_reg(CFG_DEADZONE, dz);
    write_reg(CFG_FIRST_DELAY, fd);
    write_reg(CFG_REPEAT_PERIOD, rp);
    write_reg(CFG_REPEAT_ENABLE, en);
    @(posedge clk_i);
    queue_random(n, tick_pct);
  endtask

  // Event driver: offers the next queued event at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_ch.valid || in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (event_q.size() > 0) begin
        cur_ev = event_q.pop_front();
        in_ch.cmd         <= cur_ev.cmd;
        in_ch.button      <= cur_ev.button;
        in_ch.axis_select <= cur_ev.axis_select;
        in_ch.axis_value  <= cur_ev.axis_value;
        in_ch.valid       <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 3);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Every event transfer updates the predicted state; a tick queues its masks.
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      if (apply_event(cur_ev, tick_res)) tick_masks_q.push_back(tick_res);
    end
  end

  // Result receiver: short random stalls, and one long hold-off on request.
  always @(negedge clk_i) begin
    if (long_stall_req) begin
      long_stall_req = 1'b0;
      stall_left     = StallLen;
    end
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) out_gap = $urandom_range(1, 3);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (tick_masks_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected tick result: pressed %02h held %02h released %02h",
                   out_ch.pressed_mask, out_ch.held_mask, out_ch.released_mask);
        end
      end else begin
        want = tick_masks_q.pop_front();
        if (out_ch.pressed_mask !== want.pressed_mask || out_ch.held_mask !== want.held_mask
            || out_ch.released_mask !== want.released_mask) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tick result mismatch: expected p %02h h %02h r %02h, got p %02h h %02h r %02h",
                     want.pressed_mask, want.held_mask, want.released_mask,
                     out_ch.pressed_mask, out_ch.held_mask, out_ch.released_mask);
          end
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("button_edge_autorepeat regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_DEADZONE;
    cfg_data_i        = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_PRESS;
    in_ch.button      = '0;
    in_ch.axis_select = 1'b0;
    in_ch.axis_value  = '0;
    out_ch.ready      = 1'b0;
    cur_ev            = '0;
    idle_on           = 1'b1;
    long_stall_req    = 1'b0;
    mismatches        = 0;
    idle_cycles       = 0;
    for (int i = 0; i < NumBtn; i++) btn_phase[i] = PH_OFF;
    for (int d = 0; d < NumDirs; d++) hold_cnt[d] = '0;
    stick_x = 0;
    stick_y = 0;
    dz_cfg  = DeadzoneRst;
    fd_cfg  = FirstDelayRst;
    rp_cfg  = RepeatPeriodRst;
    en_cfg  = 1'b1;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    queue_directed();
    run_phase(8192, 30, 12, 1, 200, 40);

    // Tightest settings; the receiver holds off while ticks keep arriving.
    run_phase(1, 1, 1, 1, 150, 50);
    long_stall_req = 1'b1;
    drain();
    queue_random(100, 50);

    run_phase(32767, 255, 255, 1, 150, 45);
    // With repeat off the hold counts must stay frozen into the next phase.
    run_phase(100, 3, 2, 0, 150, 40);
    run_phase(20000, 2, 5, 1, 150, 40);

    drain();
    idle_on = 1'b0;
    run_phase(8192, 4, 3, 1, 200, 40);

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("button_edge_autorepeat regression: pass");
    end else begin
      $display("button_edge_autorepeat regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bea_pkg.sv
rtl/bea_in_if.sv
rtl/bea_out_if.sv
rtl/bea_cfg_regs.sv
rtl/bea_core.sv
rtl/button_edge_autorepeat.sv
verif/button_edge_autorepeat_tb.sv
